/* src/bghd_pkg.sv */
// Shared constants, register codes and divider interface types for the
// battery-gated heater drive. No dependencies; imported by every module.
package bghd_pkg;

    localparam int DivNumW = 24;
    localparam int DivDenW = 16;
    localparam int DivCntW = 5;

    localparam logic [DivNumW-1:0] FilterNum = 24'd4501200;
    localparam logic [DivDenW-1:0] FilterDen = 16'd100;
    localparam logic [DivNumW-1:0] PctScale  = 24'd100;
    localparam logic [2:0]         PressLimit = 3'd5;
    localparam logic [15:0]        VoltMax   = 16'hFFFF;
    localparam logic [7:0]         PctMax    = 8'hFF;

    localparam logic [1:0] MODE_LOW  = 2'd0;
    localparam logic [1:0] MODE_MID  = 2'd1;
    localparam logic [1:0] MODE_HIGH = 2'd2;

    typedef enum logic [2:0] {
        CFG_DUTY_LOW   = 3'd0,
        CFG_DUTY_MID   = 3'd1,
        CFG_DUTY_HIGH  = 3'd2,
        CFG_FULL_MV    = 3'd3,
        CFG_EMPTY_MV   = 3'd4,
        CFG_WINDOW_MS  = 3'd5,
        CFG_MEASURE_MS = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic               start;
        logic [DivNumW-1:0] num;
        logic [DivDenW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DivNumW-1:0] quot;
    } t_div_rsp;

endpackage

/* src/battery_gated_heater_drive_unit.sv */
// Top level of the battery-gated heater drive: control pass sequencer,
// configuration registers and result register. Depends on bghd_pkg and bghd_div.
//
// Each input transaction is one control pass and yields exactly one result
// transaction. The block works on one pass at a time: o_stall stays high from
// the accepted pass until its result has been moved into the output register.
// The pass time is set by the shared bit-serial divider. A pass without a voltage
// measurement needs one percent division; a pass whose measure period has run out
// first divides the reference constant by the ADC reading and then the filter sum
// by 100 before the percent division. When the battery is below the empty level,
// or the full level is not above the empty level, the percent division is skipped.
// A zero ADC reading needs no division for the filter. A finished result waits in
// ST_DONE while the output register is full and stalled. The output register holds
// a finished result while the next transaction is already being processed.
// Configuration writes are taken at any time but are only meant while the
// block is idle.
module battery_gated_heater_drive_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // Input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_now_ms,
    input  logic [9:0]  i_adc_sample,
    input  logic        i_fire_held,
    input  logic        i_up_event,
    input  logic        i_down_event,
    input  logic        i_power_event,
    // Result channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_pwm_duty,
    output logic [1:0]  o_mode_now,
    output logic [7:0]  o_charge_pct,
    output logic        o_low_battery,
    output logic        o_sleep_request,
    output logic [15:0] o_filtered_mv
);
    import bghd_pkg::*;

    // Pass sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_DIV_ADC = 6'b000010,
        ST_DIV_AVG = 6'b000100,
        ST_CHARGE  = 6'b001000,
        ST_DIV_PCT = 6'b010000,
        ST_DONE    = 6'b100000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [7:0]  r_duty_low;
    logic [7:0]  r_duty_mid;
    logic [7:0]  r_duty_high;
    logic [15:0] r_full_mv;
    logic [15:0] r_empty_mv;
    logic [15:0] r_window_ms;
    logic [15:0] r_measure_ms;

    // Controller state carried from pass to pass.
    logic [1:0]  r_mode;
    logic [15:0] r_volt;
    logic        r_locked;
    logic [2:0]  r_press_count;
    logic [31:0] r_window_start;
    logic [31:0] r_last_measure;
    logic [7:0]  r_charge;

    // Per-pass values held until the pass completes.
    logic [7:0]  r_duty_pend;
    logic        r_sleep_pend;

    // Result register.
    logic        r_out_valid;
    logic [7:0]  r_out_duty;
    logic [1:0]  r_out_mode;
    logic [7:0]  r_out_charge;
    logic        r_out_low;
    logic        r_out_sleep;
    logic [15:0] r_out_mv;

    logic        in_accept;
    logic        out_load;
    logic [7:0]  duty_now;
    logic [1:0]  n_mode;
    logic [2:0]  n_press_count;
    logic [31:0] n_window_start;
    logic        n_sleep;
    logic        measure_due;
    logic [DivNumW-1:0] old_weighted;
    logic [15:0] volt_above_empty;
    logic        volt_low;
    logic        span_valid;

    t_div_req    div_req;
    t_div_rsp    div_rsp;

    assign in_accept = i_valid && !o_stall;
    assign o_stall   = (r_state != ST_IDLE);
    assign out_load  = (r_state == ST_DONE) && (!r_out_valid || !i_stall);

    // The duty uses the mode and the lock as they stood before this pass.
    always_comb begin
        duty_now = 8'd0;
        if (i_fire_held && !r_locked) begin
            case (r_mode)
                MODE_LOW: duty_now = r_duty_low;
                MODE_MID: duty_now = r_duty_mid;
                default:  duty_now = r_duty_high;
            endcase
        end
    end

    // Up is applied before down; on up the unused mode code acts as the top mode.
    always_comb begin
        n_mode = r_mode;
        if (i_up_event) begin
            n_mode = (n_mode >= MODE_HIGH) ? MODE_LOW : n_mode + 2'd1;
        end
        if (i_down_event) begin
            n_mode = (n_mode == MODE_LOW || n_mode > MODE_HIGH) ? MODE_HIGH
                                                               : n_mode - 2'd1;
        end
    end

    // Power press counting. The window opens on the second press, and the
    // timeout check sees the press of the same pass already counted.
    always_comb begin
        n_press_count  = r_press_count;
        n_window_start = r_window_start;
        n_sleep        = 1'b0;
        if (i_power_event) begin
            if (r_press_count == 3'd1) begin
                n_window_start = i_now_ms;
            end
            n_press_count = r_press_count + 3'd1;
            if (n_press_count >= PressLimit) begin
                n_sleep       = 1'b1;
                n_press_count = 3'd0;
            end
        end
        if (n_press_count != 3'd0
                && (i_now_ms - n_window_start) > {16'd0, r_window_ms}) begin
            n_press_count  = 3'd0;
            n_window_start = i_now_ms;
        end
    end

    assign measure_due = (i_now_ms - r_last_measure) > {16'd0, r_measure_ms};

    // 96 times the old voltage, as 64x plus 32x.
    assign old_weighted = {2'd0, r_volt, 6'd0} + {3'd0, r_volt, 5'd0};

    assign volt_low         = r_volt < r_empty_mv;
    assign span_valid       = r_full_mv > r_empty_mv;
    assign volt_above_empty = r_volt - r_empty_mv;

    // Divider requests: reference over ADC, filter sum over 100, and percent.
    always_comb begin
        div_req = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && measure_due && i_adc_sample != 10'd0) begin
                    div_req.start = 1'b1;
                    div_req.num   = FilterNum;
                    div_req.den   = {6'd0, i_adc_sample};
                end
            end
            ST_DIV_ADC: begin
                if (div_rsp.done) begin
                    div_req.start = 1'b1;
                    div_req.num   = div_rsp.quot + old_weighted;
                    div_req.den   = FilterDen;
                end
            end
            ST_CHARGE: begin
                if (!volt_low && span_valid) begin
                    div_req.start = 1'b1;
                    div_req.num   = {8'd0, volt_above_empty} * PctScale;
                    div_req.den   = r_full_mv - r_empty_mv;
                end
            end
            ST_DIV_AVG, ST_DIV_PCT, ST_DONE: begin
                div_req = '0;
            end
            default: begin
                div_req = '0;
            end
        endcase
    end

    bghd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_low   <= 8'd85;
            r_duty_mid   <= 8'd170;
            r_duty_high  <= 8'd220;
            r_full_mv    <= 16'd4200;
            r_empty_mv   <= 16'd3000;
            r_window_ms  <= 16'd2000;
            r_measure_ms <= 16'd100;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DUTY_LOW:   r_duty_low   <= i_cfg_data[7:0];
                CFG_DUTY_MID:   r_duty_mid   <= i_cfg_data[7:0];
                CFG_DUTY_HIGH:  r_duty_high  <= i_cfg_data[7:0];
                CFG_FULL_MV:    r_full_mv    <= i_cfg_data;
                CFG_EMPTY_MV:   r_empty_mv   <= i_cfg_data;
                CFG_WINDOW_MS:  r_window_ms  <= i_cfg_data;
                CFG_MEASURE_MS: r_measure_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Pass sequencer and controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_mode         <= MODE_LOW;
            r_volt         <= 16'd0;
            r_locked       <= 1'b0;
            r_press_count  <= 3'd0;
            r_window_start <= 32'd0;
            r_last_measure <= 32'd0;
            r_charge       <= 8'd0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_mode         <= n_mode;
                        r_press_count  <= n_press_count;
                        r_window_start <= n_window_start;
                        if (measure_due) begin
                            r_last_measure <= i_now_ms;
                            if (i_adc_sample == 10'd0) begin
                                r_volt  <= VoltMax;
                                r_state <= ST_CHARGE;
                            end else begin
                                r_state <= ST_DIV_ADC;
                            end
                        end else begin
                            r_state <= ST_CHARGE;
                        end
                    end
                end
                ST_DIV_ADC: begin
                    if (div_rsp.done) begin
                        r_state <= ST_DIV_AVG;
                    end
                end
                ST_DIV_AVG: begin
                    if (div_rsp.done) begin
                        r_volt  <= (div_rsp.quot[DivNumW-1:16] != '0) ? VoltMax
                                                                      : div_rsp.quot[15:0];
                        r_state <= ST_CHARGE;
                    end
                end
                ST_CHARGE: begin
                    if (volt_low) begin
                        r_charge <= 8'd0;
                        r_locked <= 1'b1;
                        r_state  <= ST_DONE;
                    end else if (!span_valid) begin
                        r_charge <= PctMax;
                        r_locked <= 1'b0;
                        r_state  <= ST_DONE;
                    end else begin
                        r_state <= ST_DIV_PCT;
                    end
                end
                ST_DIV_PCT: begin
                    if (div_rsp.done) begin
                        r_charge <= (div_rsp.quot[DivNumW-1:8] != '0) ? PctMax
                                                                     : div_rsp.quot[7:0];
                        r_locked <= 1'b0;
                        r_state  <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Values of the pass that are fixed at acceptance.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_duty_pend  <= duty_now;
            r_sleep_pend <= n_sleep;
        end
    end

    // Result register: valid flag under reset, payload without.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_duty   <= r_duty_pend;
            r_out_mode   <= r_mode;
            r_out_charge <= r_charge;
            r_out_low    <= r_locked;
            r_out_sleep  <= r_sleep_pend;
            r_out_mv     <= r_volt;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pwm_duty      = r_out_duty;
    assign o_mode_now      = r_out_mode;
    assign o_charge_pct    = r_out_charge;
    assign o_low_battery   = r_out_low;
    assign o_sleep_request = r_out_sleep;
    assign o_filtered_mv   = r_out_mv;

endmodule

/* src/bghd_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on bghd_pkg for widths and the request/response types.
module bghd_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bghd_pkg::t_div_req i_req,
    output bghd_pkg::t_div_rsp o_rsp
);
    import bghd_pkg::*;

    logic [DivDenW-1:0] r_rem;
    logic [DivNumW-1:0] r_quo;
    logic [DivDenW-1:0] r_den;
    logic [DivCntW-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [DivDenW:0]   rem_sh;
    logic [DivDenW:0]   rem_sub;
    logic               ge;

    // The remainder stays below the divisor, so both arms fit DivDenW bits.
    assign rem_sh  = {r_rem, r_quo[DivNumW-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DivCntW'(DivNumW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DivDenW-1:0] : rem_sh[DivDenW-1:0];
            r_quo <= {r_quo[DivNumW-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule
